### rtl/gcd_pkg.sv
package gcd_pkg;

  localparam int NUM_DENOMS  = 13;
  localparam int IDX_W       = 4;
  localparam int LOAD_W      = 16;
  localparam int CHG_W       = 27;
  localparam int REM_W       = CHG_W + 1;
  localparam int CONST_W     = 28;
  localparam int RECIP_SHIFT = 27;
  localparam int CNT_OUT_W   = 16;
  localparam int BAL_W       = 32;
  localparam int STATUS_W    = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DENOMS - 1);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD    = 2'd0;
  localparam cmd_t CMD_SALE    = 2'd1;
  localparam cmd_t CMD_BALANCE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_CHANGE    = 3'd0,
    ST_NO_CHANGE = 3'd1,
    ST_UNDERPAID = 3'd2,
    ST_NO_STOCK  = 3'd3,
    ST_LOADED    = 3'd4,
    ST_BALANCE   = 3'd5
  } status_t;

  // face value in cents, index 0 is the largest
  function automatic logic [CONST_W-1:0] denom_value(input logic [IDX_W-1:0] idx);
    logic [CONST_W-1:0] v;
    unique case (idx)
      4'd0:    v = 28'd20000;
      4'd1:    v = 28'd10000;
      4'd2:    v = 28'd5000;
      4'd3:    v = 28'd2000;
      4'd4:    v = 28'd1000;
      4'd5:    v = 28'd500;
      4'd6:    v = 28'd200;
      4'd7:    v = 28'd100;
      4'd8:    v = 28'd50;
      4'd9:    v = 28'd25;
      4'd10:   v = 28'd10;
      4'd11:   v = 28'd5;
      4'd12:   v = 28'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // floor(2^27 / value), quotient estimate is low by at most one
  function automatic logic [CONST_W-1:0] denom_recip(input logic [IDX_W-1:0] idx);
    logic [CONST_W-1:0] v;
    unique case (idx)
      4'd0:    v = 28'd6710;
      4'd1:    v = 28'd13421;
      4'd2:    v = 28'd26843;
      4'd3:    v = 28'd67108;
      4'd4:    v = 28'd134217;
      4'd5:    v = 28'd268435;
      4'd6:    v = 28'd671088;
      4'd7:    v = 28'd1342177;
      4'd8:    v = 28'd2684354;
      4'd9:    v = 28'd5368709;
      4'd10:   v = 28'd13421772;
      4'd11:   v = 28'd26843545;
      4'd12:   v = 28'd134217728;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/gcd_in_if.sv
interface gcd_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic [gcd_pkg::IDX_W-1:0]      denom_index;
  logic [gcd_pkg::LOAD_W-1:0]     load_count;
  logic [gcd_pkg::CHG_W-1:0]      price_cents;
  logic [gcd_pkg::CHG_W-1:0]      paid_cents;

  modport source (output valid, cmd, denom_index, load_count, price_cents, paid_cents,
                  input ready);
  modport sink (input valid, cmd, denom_index, load_count, price_cents, paid_cents,
                output ready);
endinterface

### rtl/gcd_out_if.sv
interface gcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [gcd_pkg::STATUS_W-1:0]   status;
  logic [gcd_pkg::IDX_W-1:0]      used_denom;
  logic [gcd_pkg::CNT_OUT_W-1:0]  used_count;
  logic [gcd_pkg::BAL_W-1:0]      balance_cents;
  logic                           last;

  modport source (output valid, status, used_denom, used_count, balance_cents, last,
                  input ready);
  modport sink (input valid, status, used_denom, used_count, balance_cents, last,
                output ready);
endinterface

### rtl/gcd_mul.sv
module gcd_mul #(
  parameter int A_W = 28,
  parameter int B_W = 28
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

### rtl/gcd_stock.sv
module gcd_stock #(
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [gcd_pkg::IDX_W-1:0] wr_idx,
  input  logic [COUNT_BITS-1:0]     wr_data,
  input  logic [gcd_pkg::IDX_W-1:0] rd_idx,
  output logic [COUNT_BITS-1:0]     rd_data
);

  logic [COUNT_BITS-1:0] count_r [gcd_pkg::NUM_DENOMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gcd_pkg::NUM_DENOMS; i++) begin
        count_r[i] <= '0;
      end
    end else if (wr_en && (wr_idx <= gcd_pkg::LAST_IDX)) begin
      count_r[wr_idx] <= wr_data;
    end
  end

  assign rd_data = (rd_idx <= gcd_pkg::LAST_IDX) ? count_r[rd_idx] : '0;

endmodule

### rtl/greedy_change_dispenser.sv
// channel   dir  handshake          payload
// in_s      in   valid/ready        cmd, denom_index, load_count, price_cents, paid_cents
// out_s     out  valid/ready        status, used_denom, used_count, balance_cents, last
//
// load, underpaid and no change: through S_REPORT to the output register
// balance: a multiply and an accumulate step per denomination on the shared multiplier
// sale: a multiply and a compare step per denomination whose whole stock fits, a divide where
//   it does not, then an emit step per denomination up to the last one used
// rst_n clears the stock counts synchronously; in_s.ready is low while a transaction runs
// a full output register stalls only the step that writes it
module greedy_change_dispenser #(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  gcd_in_if.sink     in_s,
  gcd_out_if.source  out_s
);

  localparam int IDX_W = gcd_pkg::IDX_W;
  localparam int REM_W = gcd_pkg::REM_W;
  localparam int ND    = gcd_pkg::NUM_DENOMS;
  localparam int BAL_W = gcd_pkg::BAL_W;
  localparam int MA_W  = (COUNT_BITS > REM_W) ? COUNT_BITS : REM_W;
  localparam int MB_W  = gcd_pkg::CONST_W;
  localparam int MP_W  = MA_W + MB_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REPORT,
    S_STK_MUL,
    S_STK_CMP,
    S_DIV_MUL,
    S_DIV_BACK,
    S_DIV_FIX,
    S_DIV_ADJ,
    S_EMIT,
    S_BAL_MUL,
    S_BAL_ACC
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [REM_W-1:0]        q_r, q_nxt;
  logic [BAL_W-1:0]        acc_r, acc_nxt;
  gcd_pkg::status_t        rpt_r, rpt_nxt;
  logic [ND-1:0]           nz_r, nz_nxt;
  logic [COUNT_BITS-1:0]   used_r [ND];

  logic                    out_valid_r, out_valid_nxt;
  gcd_pkg::status_t        out_status_r, out_status_nxt;
  logic [IDX_W-1:0]        out_denom_r, out_denom_nxt;
  logic [gcd_pkg::CNT_OUT_W-1:0] out_count_r, out_count_nxt;
  logic [BAL_W-1:0]        out_bal_r, out_bal_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    used_we;
  logic [COUNT_BITS-1:0]   used_wdata;
  logic                    stk_we;
  logic [IDX_W-1:0]        stk_widx;
  logic [COUNT_BITS-1:0]   stk_wdata;
  logic [COUNT_BITS-1:0]   stk_rd;
  logic [MA_W-1:0]         mul_a;
  logic [MB_W-1:0]         mul_b;
  logic [MP_W-1:0]         mul_p;

  logic                    in_acc;
  logic                    out_free;
  logic [REM_W-1:0]        diff;
  logic [REM_W-1:0]        dval;
  logic [REM_W-1:0]        q_adj;
  logic [REM_W-1:0]        rem_adv;
  logic                    adv;
  logic [ND-1:0]           nz_hi;
  logic                    emit_last;
  logic [BAL_W:0]          bal_sum;
  logic                    bal_ovf;

  gcd_stock #(
    .COUNT_BITS(COUNT_BITS)
  ) u_stock (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (stk_we),
    .wr_idx  (stk_widx),
    .wr_data (stk_wdata),
    .rd_idx  (idx_r),
    .rd_data (stk_rd)
  );

  gcd_mul #(
    .A_W(MA_W),
    .B_W(MB_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign in_s.ready = (state_r == S_IDLE);
  assign in_acc     = in_s.valid && (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_s.ready;

  assign diff      = {1'b0, in_s.paid_cents} - {1'b0, in_s.price_cents};
  assign dval      = REM_W'(gcd_pkg::denom_value(idx_r));
  assign nz_hi     = nz_r >> idx_r;
  assign emit_last = (nz_hi[ND-1:1] == '0);
  assign bal_sum   = {1'b0, acc_r} + {1'b0, mul_p[BAL_W-1:0]};
  assign bal_ovf   = bal_sum[BAL_W] || (mul_p[MP_W-1:BAL_W] != '0);

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_STK_MUL, S_BAL_MUL: mul_a = MA_W'(stk_rd);
      S_DIV_MUL:            mul_a = MA_W'(rem_r);
      S_DIV_BACK:           mul_a = MA_W'(mul_p[gcd_pkg::RECIP_SHIFT +: REM_W]);
      default:              mul_a = '0;
    endcase
    mul_b = (state_r == S_DIV_MUL) ? gcd_pkg::denom_recip(idx_r)
                                   : gcd_pkg::denom_value(idx_r);
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    acc_nxt        = acc_r;
    rpt_nxt        = rpt_r;
    nz_nxt         = nz_r;
    out_valid_nxt  = out_valid_r && !out_s.ready;
    out_status_nxt = out_status_r;
    out_denom_nxt  = out_denom_r;
    out_count_nxt  = out_count_r;
    out_bal_nxt    = out_bal_r;
    out_last_nxt   = out_last_r;
    used_we        = 1'b0;
    used_wdata     = stk_rd;
    stk_we         = 1'b0;
    stk_widx       = idx_r;
    stk_wdata      = stk_rd - used_r[idx_r];
    q_adj          = q_r;
    rem_adv        = rem_r;
    adv            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_s.cmd)
            gcd_pkg::CMD_LOAD: begin
              stk_we    = 1'b1;
              stk_widx  = in_s.denom_index;
              stk_wdata = COUNT_BITS'(in_s.load_count);
              rpt_nxt   = gcd_pkg::ST_LOADED;
              state_nxt = S_REPORT;
            end
            gcd_pkg::CMD_SALE: begin
              if (diff[REM_W-1]) begin
                rpt_nxt   = gcd_pkg::ST_UNDERPAID;
                state_nxt = S_REPORT;
              end else if (diff == '0) begin
                rpt_nxt   = gcd_pkg::ST_NO_CHANGE;
                state_nxt = S_REPORT;
              end else begin
                rem_nxt   = diff;
                idx_nxt   = '0;
                nz_nxt    = '0;
                state_nxt = S_STK_MUL;
              end
            end
            gcd_pkg::CMD_BALANCE: begin
              idx_nxt   = '0;
              acc_nxt   = '0;
              state_nxt = S_BAL_MUL;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_REPORT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rpt_r;
          out_denom_nxt  = '0;
          out_count_nxt  = '0;
          out_bal_nxt    = (rpt_r == gcd_pkg::ST_BALANCE) ? acc_r : '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_STK_MUL: begin
        state_nxt = S_STK_CMP;
      end

      // take the whole stock of this denomination if it fits in the remainder, else divide
      S_STK_CMP: begin
        if (mul_p <= MP_W'(rem_r)) begin
          used_we        = 1'b1;
          used_wdata     = stk_rd;
          nz_nxt[idx_r]  = (stk_rd != '0);
          rem_adv        = rem_r - REM_W'(mul_p);
          adv            = 1'b1;
        end else begin
          state_nxt = S_DIV_MUL;
        end
      end

      S_DIV_MUL: begin
        state_nxt = S_DIV_BACK;
      end

      S_DIV_BACK: begin
        q_nxt     = mul_p[gcd_pkg::RECIP_SHIFT +: REM_W];
        state_nxt = S_DIV_FIX;
      end

      S_DIV_FIX: begin
        rem_nxt   = rem_r - REM_W'(mul_p);
        state_nxt = S_DIV_ADJ;
      end

      // quotient estimate low by at most one
      S_DIV_ADJ: begin
        if (rem_r >= dval) begin
          q_adj   = q_r + REM_W'(1);
          rem_adv = rem_r - dval;
        end else begin
          q_adj   = q_r;
          rem_adv = rem_r;
        end
        used_we       = 1'b1;
        used_wdata    = COUNT_BITS'(q_adj);
        nz_nxt[idx_r] = (q_adj != '0);
        adv           = 1'b1;
      end

      // commit stock and send one transaction per denomination used
      S_EMIT: begin
        if (nz_r[idx_r]) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = gcd_pkg::ST_CHANGE;
            out_denom_nxt  = idx_r;
            out_count_nxt  = gcd_pkg::CNT_OUT_W'(used_r[idx_r]);
            out_bal_nxt    = '0;
            out_last_nxt   = emit_last;
            stk_we         = 1'b1;
            if (emit_last || (idx_r == gcd_pkg::LAST_IDX)) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        end else if (idx_r == gcd_pkg::LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_BAL_MUL: begin
        state_nxt = S_BAL_ACC;
      end

      S_BAL_ACC: begin
        acc_nxt = bal_ovf ? '1 : bal_sum[BAL_W-1:0];
        if (idx_r == gcd_pkg::LAST_IDX) begin
          rpt_nxt   = gcd_pkg::ST_BALANCE;
          state_nxt = S_REPORT;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_BAL_MUL;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // next denomination of the greedy walk
    if (adv) begin
      rem_nxt = rem_adv;
      if (idx_r == gcd_pkg::LAST_IDX) begin
        idx_nxt = '0;
        if (rem_adv == '0) begin
          state_nxt = S_EMIT;
        end else begin
          rpt_nxt   = gcd_pkg::ST_NO_STOCK;
          state_nxt = S_REPORT;
        end
      end else begin
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = S_STK_MUL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    acc_r        <= acc_nxt;
    rpt_r        <= rpt_nxt;
    nz_r         <= nz_nxt;
    out_status_r <= out_status_nxt;
    out_denom_r  <= out_denom_nxt;
    out_count_r  <= out_count_nxt;
    out_bal_r    <= out_bal_nxt;
    out_last_r   <= out_last_nxt;
    if (used_we) begin
      used_r[idx_r] <= used_wdata;
    end
  end

  assign out_s.valid         = out_valid_r;
  assign out_s.status        = out_status_r;
  assign out_s.used_denom    = out_denom_r;
  assign out_s.used_count    = out_count_r;
  assign out_s.balance_cents = out_bal_r;
  assign out_s.last          = out_last_r;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int   COUNT_BITS     = 16;
  localparam int   RANDOM_ITEMS   = 455;
  localparam int   HOLD_CYCLES    = 300;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   TAIL_CYCLES    = 120;
  localparam int   MAX_REPORTS    = 40;
  localparam int   NUM_DENOMS     = gcd_pkg::NUM_DENOMS;
  localparam int   IDX_W          = gcd_pkg::IDX_W;
  localparam int   LOAD_W         = gcd_pkg::LOAD_W;
  localparam int   CHG_W          = gcd_pkg::CHG_W;
  localparam int   CNT_OUT_W      = gcd_pkg::CNT_OUT_W;
  localparam int   BAL_W          = gcd_pkg::BAL_W;
  localparam gcd_pkg::cmd_t CMD_NONE = 2'd3;

  typedef struct packed {
    gcd_pkg::cmd_t     cmd;
    logic [IDX_W-1:0]  idx;
    logic [LOAD_W-1:0] count;
    logic [CHG_W-1:0]  price;
    logic [CHG_W-1:0]  paid;
  } request_t;

  typedef struct packed {
    gcd_pkg::status_t     status;
    logic [IDX_W-1:0]     denom;
    logic [CNT_OUT_W-1:0] pieces;
    logic [BAL_W-1:0]     cents;
    logic                 last;
  } answer_t;

  logic clk;
  logic rst_n;

  gcd_in_if  in_ch ();
  gcd_out_if out_ch ();

  greedy_change_dispenser #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_ch),
    .out_s(out_ch)
  );

  logic [COUNT_BITS-1:0] coin_stock [NUM_DENOMS];
  answer_t               pending_answers [$];

  int mismatches    = 0;
  int requests_sent = 0;
  int ignored_sent  = 0;
  int answers_seen  = 0;
  int payouts       = 0;
  int idle_cycles   = 0;
  bit tx_idle       = 1'b0;
  bit rx_stall      = 1'b0;
  bit hold_req      = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic longint unsigned coin_cents(input int i);
    case (i)
      0:       return 20000;
      1:       return 10000;
      2:       return 5000;
      3:       return 2000;
      4:       return 1000;
      5:       return 500;
      6:       return 200;
      7:       return 100;
      8:       return 50;
      9:       return 25;
      10:      return 10;
      11:      return 5;
      12:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch in %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  function automatic void queue_answer(input gcd_pkg::status_t st, input int denom,
                                       input longint unsigned pieces,
                                       input longint unsigned cents, input bit last);
    answer_t a;
    a.status = st;
    a.denom  = denom[IDX_W-1:0];
    a.pieces = pieces[CNT_OUT_W-1:0];
    a.cents  = cents[BAL_W-1:0];
    a.last   = last;
    pending_answers.push_back(a);
  endfunction

  function automatic void predict_dispense(input request_t r);
    longint unsigned owed;
    longint unsigned sum;
    longint unsigned take;
    longint unsigned handed [NUM_DENOMS];
    int              final_i;
    int              i;
    case (r.cmd)
      gcd_pkg::CMD_LOAD: begin
        if (r.idx < NUM_DENOMS)
          coin_stock[r.idx] = r.count[COUNT_BITS-1:0];
        queue_answer(gcd_pkg::ST_LOADED, 0, 0, 0, 1'b1);
      end
      gcd_pkg::CMD_BALANCE: begin
        sum = 0;
        for (i = 0; i < NUM_DENOMS; i++)
          sum += longint'(coin_stock[i]) * coin_cents(i);
        if (sum > 64'hFFFF_FFFF)
          sum = 64'hFFFF_FFFF;
        queue_answer(gcd_pkg::ST_BALANCE, 0, 0, sum, 1'b1);
      end
      gcd_pkg::CMD_SALE: begin
        if (r.paid < r.price) begin
          queue_answer(gcd_pkg::ST_UNDERPAID, 0, 0, 0, 1'b1);
        end else if (r.paid == r.price) begin
          queue_answer(gcd_pkg::ST_NO_CHANGE, 0, 0, 0, 1'b1);
        end else begin
          owed    = longint'(r.paid) - longint'(r.price);
          final_i = -1;
          for (i = 0; i < NUM_DENOMS; i++) begin
            take = owed / coin_cents(i);
            if (take > coin_stock[i])
              take = 64'(coin_stock[i]);
            handed[i] = take;
            owed -= take * coin_cents(i);
            if (take != 0)
              final_i = i;
          end
          if (owed != 0) begin
            queue_answer(gcd_pkg::ST_NO_STOCK, 0, 0, 0, 1'b1);
          end else begin
            payouts++;
            for (i = 0; i < NUM_DENOMS; i++) begin
              if (handed[i] != 0) begin
                coin_stock[i] = coin_stock[i] - handed[i][COUNT_BITS-1:0];
                queue_answer(gcd_pkg::ST_CHANGE, i, handed[i], 0, i == final_i);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    gap = (tx_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= r.cmd;
    in_ch.denom_index <= r.idx;
    in_ch.load_count  <= r.count;
    in_ch.price_cents <= r.price;
    in_ch.paid_cents  <= r.paid;
    do @(posedge clk); while (!in_ch.ready);
    predict_dispense(r);
    if (r.cmd == CMD_NONE)
      ignored_sent++;
    else
      requests_sent++;
  endtask

  function automatic request_t noise_request(input gcd_pkg::cmd_t c);
    request_t r;
    r.cmd   = c;
    r.idx   = IDX_W'($urandom_range(0, 15));
    r.count = LOAD_W'($urandom_range(0, 65535));
    r.price = CHG_W'($urandom_range(0, 27'h7FF_FFFF));
    r.paid  = CHG_W'($urandom_range(0, 27'h7FF_FFFF));
    return r;
  endfunction

  function automatic request_t random_sale();
    request_t    r;
    int unsigned change;
    int          pick;
    r    = noise_request(gcd_pkg::CMD_SALE);
    pick = $urandom_range(0, 19);
    if (pick == 0)
      return r;
    r.price = CHG_W'($urandom_range(0, 99999999));
    if (pick == 1) begin
      r.paid = r.price;
    end else if (pick == 2) begin
      r.price = CHG_W'($urandom_range(1, 99999999));
      r.paid  = CHG_W'($urandom_range(0, r.price - 1));
    end else begin
      change = (pick < 15) ? $urandom_range(1, 2000) : $urandom_range(1, 200000);
      r.paid = CHG_W'(r.price + change);
    end
    return r;
  endfunction

  task automatic send_load(input int idx, input int count);
    request_t r;
    r       = noise_request(gcd_pkg::CMD_LOAD);
    r.idx   = idx[IDX_W-1:0];
    r.count = count[LOAD_W-1:0];
    send_request(r);
  endtask

  task automatic send_sale(input int unsigned price, input int unsigned paid);
    request_t r;
    r       = noise_request(gcd_pkg::CMD_SALE);
    r.price = price[CHG_W-1:0];
    r.paid  = paid[CHG_W-1:0];
    send_request(r);
  endtask

  task automatic test_empty_drawer();
    send_request(noise_request(gcd_pkg::CMD_BALANCE));
    send_sale(100, 101);
    send_sale(27'h7FF_FFFF, 0);
    send_sale(500, 500);
    send_request(noise_request(CMD_NONE));
    // a quarter alone cannot pay 30 cents
    send_load(9, 1);
    send_sale(0, 30);
  endtask

  task automatic test_full_stock();
    int i;
    send_load(15, 16'hFFFF);
    for (i = 0; i < NUM_DENOMS; i++)
      send_load(i, 16'hFFFF);
    send_request(noise_request(gcd_pkg::CMD_BALANCE));
    // one piece of every denomination
    send_sale(11109, 50000);
    send_sale(0, 27'h7FF_FFFF);
  endtask

  task automatic test_backpressure();
    int k;
    tx_idle  = 1'b0;
    rx_stall = 1'b0;
    hold_req = 1'b1;
    for (k = 0; k < 12; k++)
      send_request((k % 3 == 0) ? noise_request(gcd_pkg::CMD_BALANCE) : random_sale());
  endtask

  task automatic test_random_traffic();
    request_t r;
    int       sent;
    int       kind;
    int       mode;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode     = (sent / 40) % 4;
      tx_idle  = (mode == 0) || (mode == 2);
      rx_stall = (mode == 0) || (mode == 3);
      kind     = $urandom_range(0, 99);
      if (kind < 22) begin
        r     = noise_request(gcd_pkg::CMD_LOAD);
        r.idx = ($urandom_range(0, 15) == 0) ? IDX_W'($urandom_range(13, 15))
                                             : IDX_W'($urandom_range(0, 12));
        case ($urandom_range(0, 9))
          0:       r.count = '0;
          1:       r.count = LOAD_W'($urandom_range(0, 65535));
          default: r.count = LOAD_W'($urandom_range(0, 300));
        endcase
      end else if (kind < 30) begin
        r = noise_request(gcd_pkg::CMD_BALANCE);
      end else if (kind < 33) begin
        r = noise_request(CMD_NONE);
      end else begin
        r = random_sale();
      end
      send_request(r);
      if (r.cmd != CMD_NONE)
        sent++;
    end
  endtask

  // result side: random stalls plus the one long hold
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_stall && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_answer
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected answer, status", 0, out_ch.status);
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", want.status, out_ch.status);
        if (out_ch.used_denom !== want.denom)
          report_mismatch("used_denom", want.denom, out_ch.used_denom);
        if (out_ch.used_count !== want.pieces)
          report_mismatch("used_count", want.pieces, out_ch.used_count);
        if (out_ch.balance_cents !== want.cents)
          report_mismatch("balance_cents", want.cents, out_ch.balance_cents);
        if (out_ch.last !== want.last)
          report_mismatch("last", want.last, out_ch.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = gcd_pkg::CMD_LOAD;
    in_ch.denom_index = '0;
    in_ch.load_count  = '0;
    in_ch.price_cents = '0;
    in_ch.paid_cents  = '0;
    for (int i = 0; i < NUM_DENOMS; i++)
      coin_stock[i] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle  = 1'b1;
    rx_stall = 1'b1;
    test_empty_drawer();
    test_full_stock();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch("answers never delivered", 0, pending_answers.size());

    $display("covered %0d loads/sales/balance reads and %0d ignored codes, %0d answers checked",
             requests_sent, ignored_sent, answers_seen);
    $display("%0d sales paid out in coins, %0d mismatches", payouts, mismatches);
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
